// ===== rtl/ttg_pkg.sv =====
// Shared types and constants of the triangle tangent generator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package ttg_pkg;

    // One vertex word as it enters the block (Q16.16 fields).
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] tex_u;
        logic signed [31:0] tex_v;
    } t_vertex;

    // One result word (Q2.30 tangent plus flags).
    typedef struct packed {
        logic signed [31:0] tan_x;
        logic signed [31:0] tan_y;
        logic signed [31:0] tan_z;
        logic               degenerate;
        logic               last_corner;
    } t_result;

    // A complete triangle handed from the front to the back.
    typedef struct packed {
        t_vertex c0;
        t_vertex c1;
        t_vertex c2;
    } t_job;

    // Largest magnitude of an output component (1.0 in Q2.30).
    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

endpackage

// ===== rtl/ttg_front.sv =====
// Front end: holds the first two corners of a triangle and pushes whole triangles.
// Depends on ttg_pkg.
`timescale 1ns / 1ps

module ttg_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ttg_pkg::t_vertex i_vertex,
    input  logic            push,
    output logic            full,
    output logic            o_job_push,
    output ttg_pkg::t_job   o_job,
    input  logic            i_job_full
);
    import ttg_pkg::*;

    localparam logic [1:0] CORNER_LAST = 2'd2;

    logic [1:0] r_cnt;
    t_vertex    r_c0;
    t_vertex    r_c1;
    logic       w_acc;

    // Stall only the closing corner, and only while the job queue is full.
    assign full       = (r_cnt == CORNER_LAST) && i_job_full;
    assign w_acc      = push && !full;
    assign o_job_push = w_acc && (r_cnt == CORNER_LAST);
    assign o_job      = '{c0: r_c0, c1: r_c1, c2: i_vertex};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (w_acc) begin
            r_cnt <= (r_cnt == CORNER_LAST) ? 2'd0 : r_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && r_cnt == 2'd0) begin
            r_c0 <= i_vertex;
        end
        if (w_acc && r_cnt == 2'd1) begin
            r_c1 <= i_vertex;
        end
    end

endmodule

// ===== rtl/ttg_jobq.sv =====
// Two-entry queue of triangles between the front end and the back end.
// Depends on ttg_pkg.
`timescale 1ns / 1ps

module ttg_jobq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ttg_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output ttg_pkg::t_job o_job
);
    import ttg_pkg::*;

    t_job       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       w_wr;
    logic       w_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rd];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wr <= !r_wr;
            end
            if (w_rd) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// ===== rtl/ttg_back.sv =====
// Back end: differences, cross products, normalization, root and divide, result word.
// Depends on ttg_pkg.
`timescale 1ns / 1ps

module ttg_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ttg_pkg::t_job   i_job,
    input  logic            i_job_empty,
    output logic            o_job_pop,
    input  logic            pop,
    output logic            empty,
    output ttg_pkg::t_result o_result
);
    import ttg_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_FIT, ST_MUL, ST_PREP, ST_NORM, ST_SQ, ST_SQRT, ST_DIV, ST_DONE
    } t_state;

    typedef struct packed {
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
    } t_sq;

    typedef struct packed {
        logic [32:0] rem;
        logic [31:0] nsh;
        logic [31:0] q;
    } t_dv;

    function automatic t_sq sq_step(t_sq s);
        logic [63:0] t;
        t = s.r + s.b;
        if (s.x >= t) begin
            s.x = s.x - t;
            s.r = (s.r >> 1) + s.b;
        end else begin
            s.r = s.r >> 1;
        end
        s.b = s.b >> 2;
        return s;
    endfunction

    function automatic t_dv div_step(t_dv s, logic [30:0] root);
        logic [32:0] t;
        t     = {s.rem[31:0], s.nsh[31]};
        s.nsh = {s.nsh[30:0], 1'b0};
        if (t >= {2'b00, root}) begin
            s.rem = t - {2'b00, root};
            s.q   = {s.q[30:0], 1'b1};
        end else begin
            s.rem = t;
            s.q   = {s.q[30:0], 1'b0};
        end
        return s;
    endfunction

    t_state             r_state;
    logic [3:0]         r_k;
    logic [32:0]        r_dm [6];
    logic               r_ds [6];
    logic [32:0]        r_em [4];
    logic               r_es [4];
    logic signed [31:0] r_d  [6];
    logic signed [31:0] r_e  [4];
    logic signed [63:0] r_prod;
    logic signed [63:0] r_acc;
    logic               r_neg;
    logic signed [63:0] r_v  [3];
    logic [61:0]        r_m  [3];
    logic               r_ts [3];
    logic               r_degen;
    logic [63:0]        r_sum;
    t_sq                r_sq;
    t_dv                r_dv [3];
    logic               r_ovalid;
    logic [1:0]         r_ocnt;
    logic signed [31:0] r_otan [3];
    logic               r_odegen;

    logic signed [31:0] w_p0 [3];
    logic signed [31:0] w_p1 [3];
    logic signed [31:0] w_p2 [3];
    logic signed [31:0] w_t0 [2];
    logic signed [31:0] w_t1 [2];
    logic signed [31:0] w_t2 [2];
    logic signed [32:0] w_dd [6];
    logic signed [32:0] w_de [4];
    logic [32:0]        w_dor;
    logic [32:0]        w_eor;
    logic [1:0]         w_dsh;
    logic [1:0]         w_esh;
    logic [32:0]        w_tmp [10];
    logic signed [31:0] w_mul_a;
    logic signed [31:0] w_mul_b;
    logic signed [63:0] w_diff;
    logic signed [63:0] w_vabs [3];
    logic [61:0]        w_mor;
    logic               w_load_out;

    assign o_job_pop  = (r_state == ST_IDLE) && !i_job_empty;
    assign w_load_out = (r_state == ST_DONE) && !r_ovalid;

    // Unpack the triangle and form exact 33-bit differences.
    always_comb begin
        w_p0 = '{i_job.c0.pos_x, i_job.c0.pos_y, i_job.c0.pos_z};
        w_p1 = '{i_job.c1.pos_x, i_job.c1.pos_y, i_job.c1.pos_z};
        w_p2 = '{i_job.c2.pos_x, i_job.c2.pos_y, i_job.c2.pos_z};
        w_t0 = '{i_job.c0.tex_u, i_job.c0.tex_v};
        w_t1 = '{i_job.c1.tex_u, i_job.c1.tex_v};
        w_t2 = '{i_job.c2.tex_u, i_job.c2.tex_v};
        for (int i = 0; i < 3; i++) begin
            w_dd[i]     = {w_p1[i][31], w_p1[i]} - {w_p0[i][31], w_p0[i]};
            w_dd[3 + i] = {w_p2[i][31], w_p2[i]} - {w_p0[i][31], w_p0[i]};
        end
        for (int i = 0; i < 2; i++) begin
            w_de[i]     = {w_t1[i][31], w_t1[i]} - {w_t0[i][31], w_t0[i]};
            w_de[2 + i] = {w_t2[i][31], w_t2[i]} - {w_t0[i][31], w_t0[i]};
        end
    end

    // Joint scale: the top set bit of the OR of each group's magnitudes gives that group's shift.
    always_comb begin
        w_dor = '0;
        w_eor = '0;
        for (int i = 0; i < 6; i++) begin
            w_dor = w_dor | r_dm[i];
        end
        for (int i = 0; i < 4; i++) begin
            w_eor = w_eor | r_em[i];
        end
        w_dsh = w_dor[32] ? 2'd3 : w_dor[31] ? 2'd2 : w_dor[30] ? 2'd1 : 2'd0;
        w_esh = w_eor[32] ? 2'd3 : w_eor[31] ? 2'd2 : w_eor[30] ? 2'd1 : 2'd0;
        for (int i = 0; i < 6; i++) begin
            w_tmp[i] = r_dm[i] >> w_dsh;
        end
        for (int i = 0; i < 4; i++) begin
            w_tmp[6 + i] = r_em[i] >> w_esh;
        end
    end

    // One shared multiplier: cross products first, squares later.
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        if (r_state == ST_MUL) begin
            case (r_k[2:0])
                3'd0:    begin w_mul_a = r_e[2]; w_mul_b = r_e[1]; end
                3'd1:    begin w_mul_a = r_e[3]; w_mul_b = r_e[0]; end
                3'd2:    begin w_mul_a = r_d[3]; w_mul_b = r_e[1]; end
                3'd3:    begin w_mul_a = r_d[0]; w_mul_b = r_e[3]; end
                3'd4:    begin w_mul_a = r_d[4]; w_mul_b = r_e[1]; end
                3'd5:    begin w_mul_a = r_d[1]; w_mul_b = r_e[3]; end
                3'd6:    begin w_mul_a = r_d[5]; w_mul_b = r_e[1]; end
                default: begin w_mul_a = r_d[2]; w_mul_b = r_e[3]; end
            endcase
        end else if (r_state == ST_SQ) begin
            case (r_k[1:0])
                2'd0:    begin w_mul_a = {2'b00, r_m[0][29:0]}; end
                2'd1:    begin w_mul_a = {2'b00, r_m[1][29:0]}; end
                default: begin w_mul_a = {2'b00, r_m[2][29:0]}; end
            endcase
            w_mul_b = w_mul_a;
        end
    end

    assign w_diff = r_acc - r_prod;

    always_comb begin
        w_mor = r_m[0] | r_m[1] | r_m[2];
        for (int i = 0; i < 3; i++) begin
            w_vabs[i] = r_v[i][63] ? -r_v[i] : r_v[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_k      <= '0;
            r_ovalid <= 1'b0;
            r_ocnt   <= 2'd0;
        end else begin
            // Result word side: three words per triangle, last one marked.
            if (r_ovalid && pop) begin
                if (r_ocnt == 2'd2) begin
                    r_ovalid <= 1'b0;
                end
                r_ocnt <= r_ocnt + 2'd1;
            end
            case (r_state)
                ST_IDLE: begin
                    if (!i_job_empty) begin
                        for (int i = 0; i < 6; i++) begin
                            r_ds[i] <= w_dd[i][32];
                            r_dm[i] <= w_dd[i][32] ? $unsigned(-w_dd[i]) : $unsigned(w_dd[i]);
                        end
                        for (int i = 0; i < 4; i++) begin
                            r_es[i] <= w_de[i][32];
                            r_em[i] <= w_de[i][32] ? $unsigned(-w_de[i]) : $unsigned(w_de[i]);
                        end
                        r_state <= ST_FIT;
                    end
                end
                ST_FIT: begin
                    for (int i = 0; i < 6; i++) begin
                        r_d[i] <= r_ds[i] ? -$signed({2'b00, w_tmp[i][29:0]})
                                          :  $signed({2'b00, w_tmp[i][29:0]});
                    end
                    for (int i = 0; i < 4; i++) begin
                        r_e[i] <= r_es[i] ? -$signed({2'b00, w_tmp[6 + i][29:0]})
                                          :  $signed({2'b00, w_tmp[6 + i][29:0]});
                    end
                    r_k     <= '0;
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    // Issue product r_k, consume product r_k-1 (pairs subtract).
                    r_prod <= w_mul_a * w_mul_b;
                    if (r_k != 4'd0) begin
                        case (r_k)
                            4'd2:    r_neg  <= w_diff[63];
                            4'd4:    r_v[0] <= w_diff;
                            4'd6:    r_v[1] <= w_diff;
                            4'd8:    r_v[2] <= w_diff;
                            default: r_acc  <= r_prod;
                        endcase
                    end
                    if (r_k == 4'd8) begin
                        r_state <= ST_PREP;
                    end
                    r_k <= r_k + 4'd1;
                end
                ST_PREP: begin
                    for (int i = 0; i < 3; i++) begin
                        r_m[i]  <= w_vabs[i][61:0];
                        r_ts[i] <= r_neg ? (!r_v[i][63] && r_v[i] != '0) : r_v[i][63];
                    end
                    r_degen <= (r_v[0] == '0) && (r_v[1] == '0) && (r_v[2] == '0);
                    r_state <= ((r_v[0] == '0) && (r_v[1] == '0) && (r_v[2] == '0))
                               ? ST_DONE : ST_NORM;
                end
                ST_NORM: begin
                    // Bring the top set bit to position 29, four or one at a time.
                    if (w_mor[61:34] != '0) begin
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] >> 4;
                    end else if (w_mor[61:30] != '0) begin
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] >> 1;
                    end else if (w_mor[29:25] == '0) begin
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] << 4;
                    end else if (!w_mor[29]) begin
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] << 1;
                    end else begin
                        r_k     <= '0;
                        r_sum   <= '0;
                        r_state <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    r_prod <= w_mul_a * w_mul_b;
                    if (r_k != 4'd0) begin
                        r_sum <= r_sum + $unsigned(r_prod);
                    end
                    if (r_k == 4'd3) begin
                        r_sq    <= '{x: r_sum + $unsigned(r_prod), r: '0, b: 64'd1 << 62};
                        r_k     <= '0;
                        r_state <= ST_SQRT;
                    end else begin
                        r_k <= r_k + 4'd1;
                    end
                end
                ST_SQRT: begin
                    // Two root bits per cycle.
                    r_sq <= sq_step(sq_step(r_sq));
                    if (r_k == 4'd15) begin
                        for (int i = 0; i < 3; i++) begin
                            r_dv[i] <= '{rem: {5'b0, r_m[i][29:2]},
                                         nsh: {r_m[i][1:0], 30'b0}, q: '0};
                        end
                        r_state <= ST_DIV;
                    end
                    r_k <= r_k + 4'd1;
                end
                ST_DIV: begin
                    // Three lanes, two quotient bits per cycle.
                    for (int i = 0; i < 3; i++) begin
                        r_dv[i] <= div_step(div_step(r_dv[i], r_sq.r[30:0]), r_sq.r[30:0]);
                    end
                    if (r_k == 4'd15) begin
                        r_state <= ST_DONE;
                    end
                    r_k <= r_k + 4'd1;
                end
                ST_DONE: begin
                    // Hold until the result register is free.
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_ocnt   <= 2'd0;
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_odegen <= r_degen;
            for (int i = 0; i < 3; i++) begin
                if (r_degen) begin
                    r_otan[i] <= '0;
                end else begin
                    r_otan[i] <= r_ts[i] ? -$signed(r_dv[i].q) : $signed(r_dv[i].q);
                end
            end
        end
    end

    assign empty    = !r_ovalid;
    assign o_result = '{tan_x: r_otan[0], tan_y: r_otan[1], tan_z: r_otan[2],
                        degenerate: r_odegen, last_corner: (r_ocnt == 2'd2)};

endmodule

// ===== rtl/triangle_tangent_generator_top.sv =====
// Top level of the triangle tangent generator: front end, job queue, back end.
// Depends on ttg_pkg, ttg_front, ttg_jobq and ttg_back.
`timescale 1ns / 1ps

// Vertex words of a triangle list go in through push/full, one corner per word,
// positions and texture coordinates in Q16.16. The first two corners of a triangle
// are never stalled and give no result. The third corner hands the triangle to a
// two-entry queue, so the front keeps taking vertices while the back works, until
// the queue is full. The back works one triangle at a time: it forms and jointly
// scales the differences, runs the cross products on the single shared 32x32
// multiplier, takes magnitudes, block-normalizes the tangent, sums the squares,
// takes the square root and does the three divides (both two bits per cycle), then
// loads the result register. A zero-length tangent skips normalization, sum of
// squares, root and divide. The back waits in its last state while the result
// register still holds words of the previous triangle. Each triangle then yields
// three result words with the same tangent on empty/pop, unit tangent in Q2.30,
// with last_corner on the third; a zero-length tangent reads as zero with
// degenerate set. The result register lets the back start the next triangle while
// words still wait.
module triangle_tangent_generator_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ttg_pkg::t_vertex i_vertex,
    input  logic             push,
    output logic             full,
    output ttg_pkg::t_result o_result,
    output logic             empty,
    input  logic             pop
);
    import ttg_pkg::*;

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    t_job q_in;
    t_job q_out;

    // Store corners, push whole triangles.
    ttg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vertex   (i_vertex),
        .push       (push),
        .full       (full),
        .o_job_push (q_push),
        .o_job      (q_in),
        .i_job_full (q_full)
    );

    // Decouple the two sides.
    ttg_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_job   (q_out)
    );

    // Compute and emit.
    ttg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (q_out),
        .i_job_empty (q_empty),
        .o_job_pop   (q_pop),
        .pop         (pop),
        .empty       (empty),
        .o_result    (o_result)
    );

    // A degenerate word carries an all-zero tangent.
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.degenerate) |->
        (o_result.tan_x == '0 && o_result.tan_y == '0 && o_result.tan_z == '0))
        else $error("degenerate word with nonzero tangent");

    // No component exceeds one in magnitude.
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.tan_x <= ONE_Q30 && o_result.tan_x >= -ONE_Q30 &&
                    o_result.tan_y <= ONE_Q30 && o_result.tan_y >= -ONE_Q30 &&
                    o_result.tan_z <= ONE_Q30 && o_result.tan_z >= -ONE_Q30))
        else $error("tangent component out of range");

    // Words of one triangle follow without a gap.
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_result.last_corner) |=> !empty)
        else $error("triangle words broken up");

    // The front stalls only on a full job queue.
    a_full_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> q_full)
        else $error("front stalled without full queue");

endmodule

// ===== bench/ttg_checker.sv =====
// Checker for the triangle tangent generator: watches both queues, predicts results.
// Depends on ttg_pkg; instantiated by tb beside the block.
`timescale 1ns / 1ps

module ttg_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ttg_pkg::t_vertex i_vertex,
    input  logic             i_push,
    input  logic             i_full,
    input  ttg_pkg::t_result i_result,
    input  logic             i_empty,
    input  logic             i_pop,
    output int               o_fail_count,
    output int               o_tangents_waiting
);
    import ttg_pkg::*;

    t_result tangent_q[$];
    int      corner_cnt;
    t_vertex corner0, corner1;

    assign o_tangents_waiting = tangent_q.size();

    function automatic longint unsigned mag(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // Shift a group right jointly until every magnitude is below 2^30.
    function automatic void fit_group(ref longint v[6], input int n);
        longint unsigned mx;
        int s;
        mx = 0;
        s  = 0;
        for (int i = 0; i < n; i++) if (mag(v[i]) > mx) mx = mag(v[i]);
        while ((mx >> s) >= 64'd1 << 30) s++;
        for (int i = 0; i < n; i++)
            v[i] = (v[i] < 0) ? -longint'(mag(v[i]) >> s) : longint'(mag(v[i]) >> s);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic t_result tangent_of(t_vertex a, t_vertex b, t_vertex c);
        longint d[6], e[6], t[3];
        longint unsigned m[3], mx, sum, r, q;
        logic neg;
        t_result w;
        d[0] = longint'(b.pos_x) - a.pos_x;  d[3] = longint'(c.pos_x) - a.pos_x;
        d[1] = longint'(b.pos_y) - a.pos_y;  d[4] = longint'(c.pos_y) - a.pos_y;
        d[2] = longint'(b.pos_z) - a.pos_z;  d[5] = longint'(c.pos_z) - a.pos_z;
        e[0] = longint'(b.tex_u) - a.tex_u;  e[1] = longint'(b.tex_v) - a.tex_v;
        e[2] = longint'(c.tex_u) - a.tex_u;  e[3] = longint'(c.tex_v) - a.tex_v;
        e[4] = 0;
        e[5] = 0;
        fit_group(d, 6);
        fit_group(e, 4);
        neg = (e[2] * e[1] - e[3] * e[0]) < 0;
        for (int i = 0; i < 3; i++) begin
            t[i] = d[3+i] * e[1] - d[i] * e[3];
            if (neg) t[i] = -t[i];
        end
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = mag(t[i]);
            if (m[i] > mx) mx = m[i];
        end
        w = '0;
        if (mx == 0) begin
            w.degenerate = 1'b1;
            return w;
        end
        while (mx >= 64'd1 << 30) begin
            mx >>= 1;
            for (int i = 0; i < 3; i++) m[i] >>= 1;
        end
        while (mx < 64'd1 << 29) begin
            mx <<= 1;
            for (int i = 0; i < 3; i++) m[i] <<= 1;
        end
        sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        r = int_sqrt(sum);
        if (r == 0) r = 1;
        q = (m[0] << 30) / r;  w.tan_x = (t[0] < 0) ? -q[31:0] : q[31:0];
        q = (m[1] << 30) / r;  w.tan_y = (t[1] < 0) ? -q[31:0] : q[31:0];
        q = (m[2] << 30) / r;  w.tan_z = (t[2] < 0) ? -q[31:0] : q[31:0];
        return w;
    endfunction

    always @(posedge i_clk) begin
        t_result want, tan;
        if (!i_rst_n) begin
            corner_cnt   <= 0;
            o_fail_count <= 0;
        end else begin
            if (i_pop && !i_empty) begin
                if (tangent_q.size() == 0) begin
                    $display("%0t: unexpected word %h", $time, i_result);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = tangent_q.pop_front();
                    if (i_result !== want) begin
                        $display("%0t: mismatch expected %h actual %h", $time, want, i_result);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_push && !i_full) begin
                if (corner_cnt == 0) begin
                    corner0 = i_vertex;
                    corner_cnt <= 1;
                end else if (corner_cnt == 1) begin
                    corner1 = i_vertex;
                    corner_cnt <= 2;
                end else begin
                    tan = tangent_of(corner0, corner1, i_vertex);
                    for (int k = 0; k < 3; k++) begin
                        tan.last_corner = (k == 2);
                        tangent_q.insert(tangent_q.size(), tan);
                    end
                    corner_cnt <= 0;
                end
            end
        end
    end
endmodule

// ===== bench/tb.sv =====
// Testbench top: drives vertex words into the tangent generator and gives the verdict.
// Depends on ttg_pkg, ttg_checker and triangle_tangent_generator_top.
`timescale 1ns / 1ps

module tb;
    import ttg_pkg::*;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    t_vertex vertex_word = '0;
    logic    push = 1'b0;
    logic    pop = 1'b0;
    logic    full, empty;
    t_result result_word;
    int      fail_count, tangents_waiting;
    int      send_idle_pct = 13;
    int      recv_idle_pct = 83;

    always #1 i_clk = ~i_clk;

    triangle_tangent_generator_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vertex(vertex_word),
        .push    (push),
        .full    (full),
        .o_result(result_word),
        .empty   (empty),
        .pop     (pop)
    );

    ttg_checker chk (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_vertex          (vertex_word),
        .i_push            (push),
        .i_full            (full),
        .i_result          (result_word),
        .i_empty           (empty),
        .i_pop             (pop),
        .o_fail_count      (fail_count),
        .o_tangents_waiting(tangents_waiting)
    );

    // Receiver: stall pop at random at the current idle rate.
    always @(posedge i_clk) begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Pick a coordinate: mostly small, sometimes extreme or fully random.
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2, 3:    return $urandom();
            default: return $urandom_range(2047) - 1024 << 8;
        endcase
    endfunction

    function automatic t_vertex rand_vertex();
        t_vertex v;
        v.pos_x = rand_coord();
        v.pos_y = rand_coord();
        v.pos_z = rand_coord();
        v.tex_u = rand_coord();
        v.tex_v = rand_coord();
        return v;
    endfunction

    // Hold the word until accepted; insert sender gaps at random.
    // Push stays high after the accept; the next gap or drain drops it.
    task automatic send_word(t_vertex v);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        vertex_word <= v;
        push        <= 1'b1;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    task automatic send_triangle(t_vertex a, t_vertex b, t_vertex c);
        send_word(a);
        send_word(b);
        send_word(c);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge i_clk);
        while (tangents_waiting != 0) @(posedge i_clk);
    endtask

    initial begin
        t_vertex a, b, c;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: ordinary, degenerate, zero UV orientation, flipped orientation.
        a = '0; b = '0; c = '0;
        b.pos_x = 32'h0001_0000; b.tex_u = 32'h0001_0000;
        c.pos_y = 32'h0001_0000; c.tex_v = 32'h0001_0000;
        send_triangle(a, b, c);
        send_triangle(a, a, a);
        b.tex_v = 32'h0001_0000; c.tex_u = 32'h0001_0000; c.tex_v = 32'h0001_0000;
        send_triangle(a, b, c);
        b.tex_u = 32'h0001_0000; b.tex_v = 0; c.tex_u = 0; c.tex_v = 32'hffff_0000;
        send_triangle(a, b, c);
        // Field extremes: every bit of every field toggles.
        a = {5{32'h8000_0000}}; b = {5{32'h7fff_ffff}}; c = '1;
        send_triangle(a, b, c);
        send_triangle(b, a, '0);
        a = {32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h7fff_ffff, 32'h8000_0000};
        send_triangle(a, c, b);

        // Pause until every tangent has come back.
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 83 : 0;
            recv_idle_pct = (phase == 0) ? 83 : (phase == 1) ? 13 : 0;
            for (int n = 0; n < 40; n++) begin
                a = rand_vertex();
                b = rand_vertex();
                // Occasionally reuse corners to reach degenerate tangents.
                c = ($urandom_range(7) == 0) ? a : rand_vertex();
                if ($urandom_range(9) == 0) c.tex_u = a.tex_u;
                send_triangle(a, b, c);
            end
        end

        // Leave a triangle half built: it must give nothing.
        send_word(rand_vertex());
        wait_drained();
        repeat (200) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Limit: slowest run is far below this.
    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/ttg_pkg.sv
rtl/ttg_front.sv
rtl/ttg_jobq.sv
rtl/ttg_back.sv
rtl/triangle_tangent_generator_top.sv
bench/ttg_checker.sv
bench/tb.sv
